/* hdl/adx_pkg.sv */
// Shared types, constants and header byte lookup for the ArtDmx packet framer.
`timescale 1ns / 1ps

package adx_pkg;

    localparam int BYTE_W      = 8;
    localparam int UNIV_W      = 15;
    localparam int LEN_W       = 10;
    localparam int MAX_PAYLOAD = 512;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [4:0] step_t;

    // Byte positions within one packet; payload and pad positions follow the header.
    localparam step_t STEP_FIRST   = 5'd0;
    localparam step_t HDR_OP_LO    = 5'd8;
    localparam step_t HDR_OP_HI    = 5'd9;
    localparam step_t HDR_VER_HI   = 5'd10;
    localparam step_t HDR_VER_LO   = 5'd11;
    localparam step_t HDR_SEQ      = 5'd12;
    localparam step_t HDR_PHYS     = 5'd13;
    localparam step_t HDR_UNI_LO   = 5'd14;
    localparam step_t HDR_UNI_HI   = 5'd15;
    localparam step_t HDR_LEN_HI   = 5'd16;
    localparam step_t HDR_LEN_LO   = 5'd17;
    localparam step_t STEP_DATA    = 5'd18;
    localparam step_t STEP_PAD     = 5'd19;

    localparam logic [15:0] OPCODE_DMX  = 16'h5000;
    localparam logic [15:0] PROTO_VER   = 16'h000E;
    localparam logic [7:0]  SEQ_FIRST   = 8'h01;
    localparam logic [7:0]  SEQ_LAST    = 8'hFF;
    localparam logic [LEN_W-1:0] EMPTY_LEN = 10'd2;

    localparam logic [7:0] ID_BYTES [8] = '{
        8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
    };

    typedef struct packed {
        logic              first;
        logic              empty;
        logic              last;
        logic              pad;
        logic [7:0]        seq;
        logic [UNIV_W-1:0] universe;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] value;
    } cmd_t;

    function automatic logic [7:0] hdr_byte(
        input step_t             step,
        input logic [7:0]        seq,
        input logic [UNIV_W-1:0] universe,
        input logic [LEN_W-1:0]  len
    );
        logic [7:0] b;
        b = 8'h00;
        if (step < HDR_OP_LO)
        begin
            b = ID_BYTES[step[2:0]];
        end
        else
        begin
            unique case (step)
                HDR_OP_LO:  b = OPCODE_DMX[7:0];
                HDR_OP_HI:  b = OPCODE_DMX[15:8];
                HDR_VER_HI: b = PROTO_VER[15:8];
                HDR_VER_LO: b = PROTO_VER[7:0];
                HDR_SEQ:    b = seq;
                HDR_PHYS:   b = 8'h00;
                HDR_UNI_LO: b = universe[7:0];
                HDR_UNI_HI: b = {1'b0, universe[14:8]};
                HDR_LEN_HI: b = {6'b0, len[9:8]};
                HDR_LEN_LO: b = len[7:0];
                default:    b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

/* hdl/adx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module adx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/adx_front.sv */
// Front end: accept items, classify them, pick and advance the sequence counter.
`timescale 1ns / 1ps

module adx_front #(
    parameter int NUM_SEQ_COUNTERS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [adx_pkg::UNIV_W-1:0]   universe,
    input  logic [adx_pkg::LEN_W-1:0]    payload_length,
    input  logic [adx_pkg::BYTE_W-1:0]   value,
    input  logic                         last_value,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output adx_pkg::cmd_t                cmd
);

    localparam int IDX_W       = (NUM_SEQ_COUNTERS > 1) ? $clog2(NUM_SEQ_COUNTERS) : 1;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = adx_pkg::UNIV_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((33'd1 << RECIP_SHIFT) / NUM_SEQ_COUNTERS);
    localparam logic [9:0] NUM_W = 10'(NUM_SEQ_COUNTERS);
    localparam logic [adx_pkg::LEN_W-1:0] MAX_LEN = adx_pkg::LEN_W'(adx_pkg::MAX_PAYLOAD);

    // Packet tracking at the input side
    logic in_pkt_reg, in_pkt_next;
    logic pad_reg, pad_next;

    logic                        accept;
    logic                        advance;
    logic [adx_pkg::LEN_W-1:0]   plen_sat;
    logic                        is_first, is_empty, pad_new;
    adx_pkg::cmd_t               a_in;
    logic [PROD_W-1:0]           prod;

    // Stage A: classified item and quotient estimate
    logic                        a_valid_reg;
    adx_pkg::cmd_t               a_cmd_reg;
    logic [adx_pkg::UNIV_W-1:0]  a_quot_reg;

    // Stage B: counter index
    logic                        b_valid_reg;
    adx_pkg::cmd_t               b_cmd_reg;
    logic [IDX_W-1:0]            b_idx_reg;
    logic [23:0]                 qn;
    logic [23:0]                 rem_wide;
    logic [9:0]                  rem;
    logic [9:0]                  rem_fix;

    // Stage C: counter read and update
    logic                        c_valid_reg;
    adx_pkg::cmd_t               c_cmd_reg;
    logic [IDX_W-1:0]            c_idx_reg;
    logic                        c_hit_reg;
    logic [7:0]                  c_hit_data_reg;

    logic [NUM_SEQ_COUNTERS-1:0] seq_vld_reg;
    logic [IDX_W-1:0]            rd_addr;
    logic [7:0]                  rd_data;
    logic                        wr_en;
    logic [7:0]                  seq_cur;
    logic [7:0]                  seq_upd;

    assign advance  = !c_valid_reg || cmd_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    always_comb
    begin
        plen_sat = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
        is_first = !in_pkt_reg;
        is_empty = (plen_sat == '0);
        pad_new  = plen_sat[0];

        a_in          = '0;
        a_in.first    = is_first;
        a_in.empty    = is_first && is_empty;
        a_in.last     = last_value;
        a_in.pad      = is_first ? pad_new : pad_reg;
        a_in.universe = universe;
        a_in.len      = is_empty ? adx_pkg::EMPTY_LEN
                                 : plen_sat + adx_pkg::LEN_W'(pad_new);
        a_in.value    = value;

        in_pkt_next = in_pkt_reg;
        pad_next    = pad_reg;
        if (accept)
        begin
            pad_next = a_in.pad;
            if ((is_first && is_empty) || last_value)
            begin
                in_pkt_next = 1'b0;
            end
            else
            begin
                in_pkt_next = 1'b1;
            end
        end

        prod = PROD_W'(universe) * PROD_W'(RECIP);
    end

    // Remainder: the estimated quotient is exact or one short
    always_comb
    begin
        qn       = 24'(a_quot_reg) * 24'(NUM_W);
        rem_wide = 24'(a_cmd_reg.universe) - qn;
        rem      = rem_wide[9:0];
        rem_fix  = (rem >= NUM_W) ? rem - NUM_W : rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pkt_reg  <= 1'b0;
            pad_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            c_hit_reg   <= 1'b0;
            seq_vld_reg <= '0;
        end
        else
        begin
            in_pkt_reg <= in_pkt_next;
            pad_reg    <= pad_next;
            if (advance)
            begin
                a_valid_reg <= in_valid;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                c_hit_reg   <= wr_en && (c_idx_reg == b_idx_reg);
            end
            if (wr_en)
            begin
                seq_vld_reg[c_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_cmd_reg      <= a_in;
            a_quot_reg     <= prod[RECIP_SHIFT +: adx_pkg::UNIV_W];
            b_cmd_reg      <= a_cmd_reg;
            b_idx_reg      <= rem_fix[IDX_W-1:0];
            c_cmd_reg      <= b_cmd_reg;
            c_idx_reg      <= b_idx_reg;
            c_hit_data_reg <= seq_upd;
        end
    end

    // Hold the read address while stage C stalls so the read data stays current
    assign rd_addr = advance ? b_idx_reg : c_idx_reg;

    always_comb
    begin
        if (c_hit_reg)
        begin
            seq_cur = c_hit_data_reg;
        end
        else if (seq_vld_reg[c_idx_reg])
        begin
            seq_cur = rd_data;
        end
        else
        begin
            seq_cur = adx_pkg::SEQ_FIRST;
        end
        seq_upd = (seq_cur == adx_pkg::SEQ_LAST) ? adx_pkg::SEQ_FIRST : seq_cur + 8'd1;
        wr_en   = c_valid_reg && cmd_ready && c_cmd_reg.first;

        cmd     = c_cmd_reg;
        cmd.seq = seq_cur;
    end

    assign cmd_valid = c_valid_reg;

    adx_ram #(
        .WIDTH (8),
        .DEPTH (NUM_SEQ_COUNTERS)
    ) u_seq_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (c_idx_reg),
        .wr_data (seq_upd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

/* hdl/adx_fifo.sv */
// Short command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module adx_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  adx_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_ready,
    output adx_pkg::cmd_t rd_cmd
);

    localparam int PTR_W = (adx_pkg::QUEUE_DEPTH > 1) ? $clog2(adx_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(adx_pkg::QUEUE_DEPTH + 1);

    adx_pkg::cmd_t    slot_reg [adx_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(adx_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(adx_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(adx_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

/* hdl/adx_back.sv */
// Back end: expand each command into packet bytes through an output register.
`timescale 1ns / 1ps

module adx_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  adx_pkg::cmd_t              cmd,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [adx_pkg::BYTE_W-1:0] packet_byte,
    output logic                       end_of_packet
);

    logic                       started_reg, started_next;
    adx_pkg::step_t             step_reg, step_next;
    logic                       out_valid_reg, out_valid_next;
    logic [adx_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       eop_reg, eop_next;

    adx_pkg::step_t             cur;
    logic                       load, fire, final_step;

    always_comb
    begin
        load = !out_valid_reg || out_ready;
        fire = cmd_valid && load;

        if (started_reg)
        begin
            cur = step_reg;
        end
        else
        begin
            cur = cmd.first ? adx_pkg::STEP_FIRST : adx_pkg::STEP_DATA;
        end

        final_step = (cur == adx_pkg::STEP_PAD) ||
                     ((cur == adx_pkg::STEP_DATA) && !cmd.empty && !(cmd.last && cmd.pad));

        if (cur < adx_pkg::STEP_DATA)
        begin
            byte_next = adx_pkg::hdr_byte(cur, cmd.seq, cmd.universe, cmd.len);
        end
        else if ((cur == adx_pkg::STEP_DATA) && !cmd.empty)
        begin
            byte_next = cmd.value;
        end
        else
        begin
            byte_next = '0;
        end

        eop_next = (cur == adx_pkg::STEP_PAD) ||
                   ((cur == adx_pkg::STEP_DATA) && !cmd.empty && cmd.last && !cmd.pad);

        started_next   = started_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = cmd_valid;
        end
        if (fire)
        begin
            started_next = !final_step;
            step_next    = cur + 5'd1;
        end

        cmd_ready = fire && final_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            step_reg      <= adx_pkg::STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= byte_next;
            eop_reg  <= eop_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign packet_byte   = byte_reg;
    assign end_of_packet = eop_reg;

endmodule

/* hdl/artdmx_packet_framer.sv */
// Top level of the ArtDmx packet framer: front end, command queue and byte sequencer.
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// -------  ----------------------  -----------------------------------------------
// input    in_valid / in_ready     universe, payload_length, value, last_value
// output   out_valid / out_ready   packet_byte, end_of_packet
//
// Bytes: a payload byte gives one output byte; the first item of a packet gives 19
//   (18 header bytes plus its own), a closing pad byte one more, an empty packet 20.
//   Output at one byte per cycle while out_ready is high sets the sustained rate.
// Path: an item passes three front stages, the queue and the output register before
//   its first output byte is valid.
// Reset: clears all control state; counter entries read as one until first written,
//   so there is no clearing pass after reset.
// Stalls: the queue lets the front keep accepting while header bytes drain, and the
//   output register holds a finished byte while out_ready is low.

module artdmx_packet_framer #(
    parameter int NUM_SEQ_COUNTERS = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [adx_pkg::UNIV_W-1:0] universe,
    input  logic [adx_pkg::LEN_W-1:0]  payload_length,
    input  logic [adx_pkg::BYTE_W-1:0] value,
    input  logic                       last_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [adx_pkg::BYTE_W-1:0] packet_byte,
    output logic                       end_of_packet
);

    // Front to queue
    logic          fq_valid;
    logic          fq_ready;
    adx_pkg::cmd_t fq_cmd;

    // Queue to sequencer
    logic          qb_valid;
    logic          qb_ready;
    adx_pkg::cmd_t qb_cmd;

    // Classify items, saturate the length and pick the sequence number per packet
    adx_front #(
        .NUM_SEQ_COUNTERS (NUM_SEQ_COUNTERS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .universe       (universe),
        .payload_length (payload_length),
        .value          (value),
        .last_value     (last_value),
        .cmd_valid      (fq_valid),
        .cmd_ready      (fq_ready),
        .cmd            (fq_cmd)
    );

    // Decouple the front from header expansion
    adx_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_cmd   (qb_cmd)
    );

    // Emit header, payload and pad bytes one transfer at a time
    adx_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (qb_valid),
        .cmd_ready     (qb_ready),
        .cmd           (qb_cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .packet_byte   (packet_byte),
        .end_of_packet (end_of_packet)
    );

endmodule
